### rtl/cmld_pkg.sv
// ----------------------------------------------------------------------------
// cmld_pkg
// shared widths, constants and stage record for the magnitude / decibel block
// ----------------------------------------------------------------------------
package cmld_pkg;

   localparam int SampleWidth = 16;
   localparam int MagWidth    = 16;
   localparam int PowerWidth  = 32;
   localparam int FracBits    = 24;
   localparam int ExpWidth    = 5;
   localparam int LogWidth    = ExpWidth + FracBits;
   localparam int MantWidth   = 31;
   localparam int SqrtSteps   = 16;
   localparam int RemWidth    = PowerWidth + 1;
   localparam int ScaleWidth  = 30;
   localparam int ScaleSplit  = 15;
   localparam int SumWidth    = 60;
   localparam int DbShift     = 44;

   // 2560*log10(2) in q.20
   localparam logic [ScaleWidth-1:0] DbScale = 30'd808071242;
   localparam logic [SumWidth-1:0]   DbBias  = 60'd4294967296;

   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic                 mode;
      logic [RemWidth-1:0]  rem;
      logic [SqrtSteps-1:0] root;
      logic [MantWidth-1:0] y;
      logic [LogWidth-1:0]  lg;
   } iter_type;

   function automatic logic [ExpWidth-1:0] top_bit(input logic [PowerWidth-1:0] v);
      logic [ExpWidth-1:0] r;
      r = '0;
      for (int i = 0; i < PowerWidth; i++) begin
         if (v[i]) r = ExpWidth'(i);
      end
      return r;
   endfunction

endpackage

### rtl/cmld_front.sv
// ----------------------------------------------------------------------------
// cmld_front
// input register, squares, power sum, exponent search and mantissa shift
// ----------------------------------------------------------------------------
module cmld_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic signed [cmld_pkg::SampleWidth-1:0] real_part,
   input  logic signed [cmld_pkg::SampleWidth-1:0] imag_part,
   input  logic                                last_in,
   input  logic                                mode,
   output cmld_pkg::iter_type                  iter_o
);
   import cmld_pkg::*;

   logic                          v0_ff, v1_ff, v2_ff, v3_ff;
   logic [1:0]                    ctl0_ff, ctl1_ff, ctl2_ff, ctl3_ff;
   logic signed [SampleWidth-1:0] re_ff, im_ff;
   logic [SampleWidth-1:0]        ar_in, ai_in;
   logic [PowerWidth-1:0]         sqr_ff, sqi_ff;
   logic [PowerWidth-1:0]         p_ff, x_ff, p3_ff, x3_ff;
   logic [ExpWidth-1:0]           e_ff;
   logic [2*PowerWidth-3:0]       shift_in;
   iter_type                      iter_ff, iter_in;

   assign ar_in = re_ff[SampleWidth-1] ? SampleWidth'(-re_ff) : SampleWidth'(re_ff);
   assign ai_in = im_ff[SampleWidth-1] ? SampleWidth'(-im_ff) : SampleWidth'(im_ff);

   always_comb begin
      shift_in       = {x3_ff, 30'b0} >> e_ff;
      iter_in.valid  = v3_ff;
      iter_in.last   = ctl3_ff[0];
      iter_in.mode   = ctl3_ff[1];
      iter_in.rem    = {1'b0, p3_ff};
      iter_in.root   = '0;
      iter_in.y      = shift_in[MantWidth-1:0];
      iter_in.lg     = {e_ff, {FracBits{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         iter_ff.valid <= 1'b0;
      end else if (adv) begin
         v0_ff   <= in_valid;
         ctl0_ff <= {mode, last_in};
         re_ff   <= real_part;
         im_ff   <= imag_part;
         v1_ff   <= v0_ff;
         ctl1_ff <= ctl0_ff;
         sqr_ff  <= PowerWidth'(ar_in) * PowerWidth'(ar_in);
         sqi_ff  <= PowerWidth'(ai_in) * PowerWidth'(ai_in);
         v2_ff   <= v1_ff;
         ctl2_ff <= ctl1_ff;
         p_ff    <= sqr_ff + sqi_ff;
         x_ff    <= sqr_ff + sqi_ff + PowerWidth'(1);
         v3_ff   <= v2_ff;
         ctl3_ff <= ctl2_ff;
         p3_ff   <= p_ff;
         x3_ff   <= x_ff;
         e_ff    <= top_bit(x_ff);
         iter_ff <= iter_in;
      end
   end

   assign iter_o = iter_ff;

endmodule

### rtl/cmld_iter.sv
// ----------------------------------------------------------------------------
// cmld_iter
// one stage per log2 fraction bit by squaring, root bits in the first stages
// ----------------------------------------------------------------------------
module cmld_iter (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  cmld_pkg::iter_type iter_i,
   output cmld_pkg::iter_type iter_o
);
   import cmld_pkg::*;

   iter_type chain [FracBits+1];
   iter_type stage_ff [FracBits];

   assign chain[0] = iter_i;

   for (genvar k = 0; k < FracBits; k++) begin : g_step
      logic [2*MantWidth-1:0] prod;
      logic [PowerWidth-1:0]  sq;
      logic [RemWidth-1:0]    rem_in;
      logic [SqrtSteps-1:0]   root_in;
      iter_type               step_in;

      if (k < SqrtSteps) begin : g_root
         logic [RemWidth-1:0] trial;
         always_comb begin
            trial   = (RemWidth'(chain[k].root) << (SqrtSteps - k))
                    + (RemWidth'(1) << (2 * (SqrtSteps - 1 - k)));
            rem_in  = chain[k].rem;
            root_in = chain[k].root;
            if (chain[k].rem >= trial) begin
               rem_in                    = chain[k].rem - trial;
               root_in[SqrtSteps-1-k]    = 1'b1;
            end
         end
      end else begin : g_hold
         assign rem_in  = chain[k].rem;
         assign root_in = chain[k].root;
      end

      always_comb begin
         prod         = (2*MantWidth)'(chain[k].y) * (2*MantWidth)'(chain[k].y);
         sq           = prod[2*MantWidth-1:30];
         step_in      = chain[k];
         step_in.rem  = rem_in;
         step_in.root = root_in;
         if (sq[PowerWidth-1]) begin
            step_in.y                 = sq[PowerWidth-1:1];
            step_in.lg[FracBits-1-k]  = 1'b1;
         end else begin
            step_in.y = sq[MantWidth-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else if (adv) begin
            stage_ff[k] <= step_in;
         end
      end

      assign chain[k+1] = stage_ff[k];
   end

   assign iter_o = chain[FracBits];

`ifndef ASSERT_OFF
   a_mant_norm: assert property (@(posedge clock) disable iff (reset)
      iter_i.valid |-> iter_i.y[MantWidth-1])
      else $error("mantissa entering the log stages is not normalized");
   a_mant_kept: assert property (@(posedge clock) disable iff (reset)
      iter_o.valid |-> iter_o.y[MantWidth-1])
      else $error("mantissa lost normalization in the log stages");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      iter_o.valid |-> iter_o.rem <= (RemWidth'(iter_o.root) << 1))
      else $error("root remainder out of range");
`endif

endmodule

### rtl/cmld_back.sv
// ----------------------------------------------------------------------------
// cmld_back
// decibel scaling by split product, mode select and output register
// ----------------------------------------------------------------------------
module cmld_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  cmld_pkg::iter_type           iter_i,
   output logic                         out_valid,
   output logic [cmld_pkg::MagWidth-1:0] magnitude,
   output logic                         last_out
);
   import cmld_pkg::*;

   logic                               va_ff, vb_ff;
   logic                               lasta_ff, modea_ff, lastb_ff;
   logic [SqrtSteps-1:0]               roota_ff;
   logic [ScaleSplit+ScaleWidth-1:0]   plo_ff;
   logic [LogWidth-ScaleSplit+ScaleWidth-1:0] phi_ff;
   logic [SumWidth-1:0]                sum_in;
   logic [MagWidth-1:0]                mag_ff, mag_in;

   always_comb begin
      sum_in = (SumWidth'(phi_ff) << ScaleSplit) + SumWidth'(plo_ff) + DbBias;
      mag_in = modea_ff ? sum_in[DbShift+MagWidth-1:DbShift] : MagWidth'(roota_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (adv) begin
         va_ff    <= iter_i.valid;
         lasta_ff <= iter_i.last;
         modea_ff <= iter_i.mode;
         roota_ff <= iter_i.root;
         plo_ff   <= (ScaleSplit+ScaleWidth)'(iter_i.lg[ScaleSplit-1:0]) *
                     (ScaleSplit+ScaleWidth)'(DbScale);
         phi_ff   <= (LogWidth-ScaleSplit+ScaleWidth)'(iter_i.lg[LogWidth-1:ScaleSplit]) *
                     (LogWidth-ScaleSplit+ScaleWidth)'(DbScale);
         vb_ff    <= va_ff;
         lastb_ff <= lasta_ff;
         mag_ff   <= mag_in;
      end
   end

   assign out_valid = vb_ff;
   assign magnitude = mag_ff;
   assign last_out  = lastb_ff;

`ifndef ASSERT_OFF
   a_lin_range: assert property (@(posedge clock) disable iff (reset)
      (adv && va_ff && !modea_ff) |=> mag_ff <= MagWidth'(46341))
      else $error("linear magnitude out of range");
   a_db_range: assert property (@(posedge clock) disable iff (reset)
      (adv && va_ff && modea_ff) |=> mag_ff <= MagWidth'(23900))
      else $error("decibel value out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(mag_ff) && $stable(vb_ff))
      else $error("output register changed during stall");
`endif

endmodule

### rtl/complex_magnitude_lin_db_top.sv
// ----------------------------------------------------------------------------
// complex_magnitude_lin_db_top
// magnitude of one complex bin per cycle, linear root or q8.8 decibels
//
// req_ channel takes one bin (signed real and imaginary, frame-end flag) per
// transfer; rsp_ channel gives one 16-bit magnitude and the copied flag.
// csr_wr_en writes log_mode from csr_wr_data[0]: 0 gives floor(sqrt(power)),
// 1 gives floor(2560*log10(power+1)); the mode is sampled with each bin.
// A bin passes the front stages, the 24 squaring stages of the log2 fraction
// and the scaling stages on its way from the req transfer to rsp_valid.
// Throughput is one bin per cycle while the output is not stalled; all stages advance together.
// When the receiver holds rsp_ready low with a result waiting, the whole
// pipeline freezes and req_ready drops; nothing is lost or repeated.
// Reset clears every stage valid bit and sets log_mode to linear.
// ----------------------------------------------------------------------------
module complex_magnitude_lin_db_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [cmld_pkg::SampleWidth-1:0]  req_real_part,
   input  logic signed [cmld_pkg::SampleWidth-1:0]  req_imag_part,
   input  logic                                     req_last_in,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [cmld_pkg::MagWidth-1:0]            rsp_magnitude,
   output logic                                     rsp_last_out,
   input  logic                                     csr_wr_en,
   input  logic                                     csr_wr_data
);
   import cmld_pkg::*;

   logic     log_mode_ff;
   logic     adv;
   iter_type front_iter, iter_back;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         log_mode_ff <= csr_wr_data;
      end
   end

   cmld_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .real_part (req_real_part),
      .imag_part (req_imag_part),
      .last_in   (req_last_in),
      .mode      (log_mode_ff),
      .iter_o    (front_iter)
   );

   cmld_iter u_iter (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .iter_i (front_iter),
      .iter_o (iter_back)
   );

   cmld_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .iter_i    (iter_back),
      .out_valid (rsp_valid),
      .magnitude (rsp_magnitude),
      .last_out  (rsp_last_out)
   );

`ifndef ASSERT_OFF
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without an output stall");
   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> log_mode_ff == $past(csr_wr_data))
      else $error("mode register write lost");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_magnitude) && $stable(rsp_last_out)))
      else $error("waiting result changed before its transfer");
`endif

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench for complex_magnitude_lin_db_top
//
// Drives complex bins through the req_ channel and checks every rsp_ transfer
// against a local predictor of floor(sqrt(power)) and of Q8.8 decibels.
// A directed table covers the sign extremes, zero and exact powers of ten.
// Random bins follow, with random idle gaps on both sides and several mode
// changes. The mode register is only written while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
   import cmld_pkg::*;

   localparam int Latency = 31;

   typedef struct {
      logic signed [SampleWidth-1:0] re;
      logic signed [SampleWidth-1:0] im;
      logic                          last;
      logic                          mode;
      int                            want;   // -1 means use predictor
   } bin_row_type;

   typedef struct {
      logic [MagWidth-1:0] mag;
      logic                last;
   } mag_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SampleWidth-1:0] req_real_part = '0;
   logic signed [SampleWidth-1:0] req_imag_part = '0;
   logic                          req_last_in = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [MagWidth-1:0]           rsp_magnitude;
   logic                          rsp_last_out;
   logic                          csr_wr_en = 1'b0;
   logic                          csr_wr_data = 1'b0;

   logic                          log_mode_shadow = 1'b0;
   mag_result_type                pending_mags[$];
   int                            mismatch_count = 0;
   int                            bins_sent = 0;
   int                            bins_checked = 0;
   int                            db_bins = 0;
   bin_row_type                   bin_table[$];

   complex_magnitude_lin_db_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_real_part(req_real_part), .req_imag_part(req_imag_part),
      .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_magnitude(rsp_magnitude), .rsp_last_out(rsp_last_out),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] bin_power(logic signed [SampleWidth-1:0] re,
                                             logic signed [SampleWidth-1:0] im);
      longint r;
      longint i;
      r = re;
      i = im;
      return 64'(r * r + i * i);
   endfunction

   function automatic logic [MagWidth-1:0] floor_root(logic [63:0] p);
      logic [63:0] root;
      logic [63:0] step;
      root = 0;
      for (int b = 16; b >= 0; b--) begin
         step = root | (64'd1 << b);
         if (step * step <= p) root = step;
      end
      return (root > 64'hFFFF) ? 16'hFFFF : root[15:0];
   endfunction

   function automatic logic [MagWidth-1:0] power_db(logic [63:0] p);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] lg;
      logic [63:0] q;
      int          e;
      x = p + 1;
      e = 0;
      while ((x >> (e + 1)) != 0) e++;
      y = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
      lg = 64'(e) << FracBits;
      for (int i = FracBits - 1; i >= 0; i--) begin
         y = (y * y) >> 30;
         if (y >= (64'd1 << 31)) begin
            lg |= 64'd1 << i;
            y = y >> 1;
         end
      end
      q = (lg * 64'd808071242 + (64'd1 << 32)) >> 44;
      return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
   endfunction

   function automatic logic [MagWidth-1:0] predict_mag(logic signed [SampleWidth-1:0] re,
                                                       logic signed [SampleWidth-1:0] im,
                                                       logic mode);
      return mode ? power_db(bin_power(re, im)) : floor_root(bin_power(re, im));
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      mismatch_count++;
   endtask

   task automatic set_log_mode(logic mode);
      req_valid <= 1'b0;
      while (pending_mags.size() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      log_mode_shadow = mode;
   endtask

   task automatic send_bin(logic signed [SampleWidth-1:0] re,
                           logic signed [SampleWidth-1:0] im,
                           logic last, int want);
      mag_result_type m;
      int             idle;
      idle = $urandom_range(0, 13) * ($urandom_range(0, 3) != 0);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_real_part <= re;
      req_imag_part <= im;
      req_last_in   <= last;
      do @(posedge clock); while (!req_ready);
      m.mag  = (want >= 0) ? MagWidth'(want) : predict_mag(re, im, log_mode_shadow);
      m.last = last;
      pending_mags.push_back(m);
      bins_sent++;
      if (log_mode_shadow) db_bins++;
   endtask

   // receiver side with random stalls
   initial begin
      int             hold;
      mag_result_type m;
      @(negedge reset);
      forever begin
         hold = $urandom_range(0, 13) * ($urandom_range(0, 3) != 0);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_mags.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_magnitude, -1);
         end else begin
            m = pending_mags.pop_front();
            if (rsp_magnitude !== m.mag) report_mismatch("magnitude", rsp_magnitude, m.mag);
            if (rsp_last_out !== m.last) report_mismatch("last_out", rsp_last_out, m.last);
            bins_checked++;
         end
      end
   end

   initial begin
      #50000000;
      $display("timeout");
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      int           slack;
      bin_row_type  row;
      logic         mode;
      logic signed [SampleWidth-1:0] re;
      logic signed [SampleWidth-1:0] im;
      // directed table: re, im, last, mode, expected
      bin_table = '{
         '{16'sd0, 16'sd0, 1'b0, 1'b0, 0},
         '{-16'sd32768, -16'sd32768, 1'b1, 1'b0, 46340},
         '{16'sd32767, 16'sd32767, 1'b0, 1'b0, 46339},
         '{-16'sd32768, 16'sd0, 1'b0, 1'b0, 32768},
         '{16'sd32767, -16'sd32768, 1'b1, 1'b0, -1},
         '{16'sd3, 16'sd4, 1'b0, 1'b0, 5},
         '{16'sd1, -16'sd1, 1'b0, 1'b0, 1},
         '{16'sd0, 16'sd0, 1'b0, 1'b1, 0},
         '{16'sd3, 16'sd0, 1'b0, 1'b1, 2560},
         '{16'sd0, -16'sd3, 1'b1, 1'b1, 2560},
         '{16'sd6, 16'sd8, 1'b0, 1'b1, -1},
         '{-16'sd32768, -16'sd32768, 1'b0, 1'b1, 23889},
         '{16'sd32767, 16'sd32767, 1'b1, 1'b1, -1},
         '{-16'sd32768, 16'sd32767, 1'b0, 1'b1, -1},
         '{16'sd1, 16'sd0, 1'b0, 1'b1, -1},
         '{-16'sd1, -16'sd1, 1'b1, 1'b1, -1},
         '{16'sd300, -16'sd400, 1'b0, 1'b1, -1},
         '{16'sd21845, -16'sd21846, 1'b1, 1'b0, -1}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (bin_table[k]) begin
         row = bin_table[k];
         if (row.mode != log_mode_shadow) set_log_mode(row.mode);
         send_bin(row.re, row.im, row.last, row.want);
      end
      for (int phase = 0; phase < 6; phase++) begin
         mode = phase[0];
         set_log_mode(mode);
         for (int n = 0; n < 125; n++) begin
            case ($urandom_range(0, 5))
               0: begin
                  re = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
                  im = SampleWidth'($urandom);
               end
               1: begin
                  re = SampleWidth'($signed($urandom_range(0, 15)) - 8);
                  im = SampleWidth'($signed($urandom_range(0, 15)) - 8);
               end
               default: begin
                  re = SampleWidth'($urandom);
                  im = SampleWidth'($urandom);
               end
            endcase
            send_bin(re, im, 1'($urandom_range(0, 1)), -1);
         end
      end
      req_valid <= 1'b0;
      slack = 0;
      while (pending_mags.size() != 0 && slack < 100000) begin
         @(posedge clock);
         slack++;
      end
      repeat (Latency + 10) @(posedge clock);
      $display("sent %0d bins (%0d in decibel mode), checked %0d results",
               bins_sent, db_bins, bins_checked);
      if (mismatch_count == 0 && pending_mags.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count,
                  pending_mags.size());
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
